/* hw/rtl/assert_macros.svh */
// Assertion macros used by the integer ALU top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

/* hw/rtl/a64alu_pkg.sv */
// Package with the types, constants and shared functions of the integer ALU.
`default_nettype none

package a64alu_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int HALF_WIDTH = DATA_WIDTH / 2;
    localparam int IMM_WIDTH  = 16;
    localparam int AMT_WIDTH  = $clog2(DATA_WIDTH);

    typedef enum logic [3:0] {
        MODE_ADD  = 4'd0,
        MODE_ADDS = 4'd1,
        MODE_SUB  = 4'd2,
        MODE_SUBS = 4'd3,
        MODE_AND  = 4'd4,
        MODE_ORR  = 4'd5,
        MODE_EOR  = 4'd6,
        MODE_MOVZ = 4'd7,
        MODE_MOVN = 4'd8,
        MODE_MOVK = 4'd9,
        MODE_EXTR = 4'd10,
        MODE_UBFM = 4'd11
    } mode_t;

    typedef enum logic [1:0] {
        SHIFT_LSL = 2'd0,
        SHIFT_LSR = 2'd1,
        SHIFT_ASR = 2'd2,
        SHIFT_ROR = 2'd3
    } shift_kind_t;

    typedef struct packed {
        logic [3:0]            mode;
        logic                  is_wide;
        logic [DATA_WIDTH-1:0] left_operand;
        logic [DATA_WIDTH-1:0] right_operand;
        logic [1:0]            shift_kind;
        logic [AMT_WIDTH-1:0]  shift_amount;
        logic                  invert_right;
        logic [DATA_WIDTH-1:0] bit_mask;
    } op_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic [3:0]            nzcv;
        logic                  flags_written;
    } res_t;

    // Mask of the active width.
    function automatic logic [DATA_WIDTH-1:0] width_mask(input logic wide);
        return wide ? {DATA_WIDTH{1'b1}} : {{HALF_WIDTH{1'b0}}, {HALF_WIDTH{1'b1}}};
    endfunction

    // Window of the concatenation {hi, lo} starting at bit amt, within the
    // active width. With hi equal to lo this is a rotate right.
    function automatic logic [DATA_WIDTH-1:0] funnel(
        input logic [DATA_WIDTH-1:0] hi,
        input logic [DATA_WIDTH-1:0] lo,
        input logic                  wide,
        input logic [AMT_WIDTH-1:0]  amt
    );
        logic [2*DATA_WIDTH-1:0] cat_full;
        logic [DATA_WIDTH-1:0]   cat_half;
        cat_full = {hi, lo} >> amt;
        cat_half = {hi[HALF_WIDTH-1:0], lo[HALF_WIDTH-1:0]} >> amt[AMT_WIDTH-2:0];
        return wide ? cat_full[DATA_WIDTH-1:0]
                    : {{HALF_WIDTH{1'b0}}, cat_half[HALF_WIDTH-1:0]};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/aarch64_integer_alu.sv */
// Integer ALU top level: operand register, datapath and result register.
//
// Usage:
//   The item channel (item_valid, item_stall) carries one operation per
//   transfer: mode, width, two operands, shift kind and amount, invert flag
//   and bit mask. The result channel (result_valid, result_stall) returns
//   exactly one transfer per item with result_value, nzcv and flags_written.
//   An item transfer loads the operand register; result_valid rises when
//   the result register then loads from the combinational datapath.
//   Throughput is one item per cycle while the result register can drain;
//   items follow each other back to back. The rate is set by the single
//   combinational pass from the operand register to the result register.
//   When the receiver stalls, the result register holds its contents and
//   the operand register holds one more item; item_stall rises only when
//   both are full and the result cannot leave.
//   Reset empties both registers; no results are pending after reset, and
//   the block keeps no state between items.
`default_nettype none
`include "assert_macros.svh"

module aarch64_integer_alu (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire logic [3:0]                        mode,
    input  wire logic                              is_wide,
    input  wire logic [a64alu_pkg::DATA_WIDTH-1:0] left_operand,
    input  wire logic [a64alu_pkg::DATA_WIDTH-1:0] right_operand,
    input  wire logic [1:0]                        shift_kind,
    input  wire logic [a64alu_pkg::AMT_WIDTH-1:0]  shift_amount,
    input  wire logic                              invert_right,
    input  wire logic [a64alu_pkg::DATA_WIDTH-1:0] bit_mask,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output logic      [a64alu_pkg::DATA_WIDTH-1:0] result_value,
    output logic      [3:0]                        nzcv,
    output logic                                   flags_written
);

    localparam int HW = a64alu_pkg::HALF_WIDTH;
    localparam int DW = a64alu_pkg::DATA_WIDTH;

    a64alu_pkg::op_t  op_reg;
    a64alu_pkg::res_t res_reg;
    a64alu_pkg::res_t res_next;
    logic             op_valid_reg;
    logic             op_valid_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic             out_blocked;
    logic             op_move;
    logic             item_take;

    a64alu_core u_core (
        .op  (op_reg),
        .res (res_next)
    );

    always_comb
    begin
        out_blocked    = res_valid_reg && result_stall;
        op_move        = op_valid_reg && !out_blocked;
        item_stall     = op_valid_reg && out_blocked;
        item_take      = item_valid && !item_stall;
        op_valid_next  = item_take || (op_valid_reg && !op_move);
        res_valid_next = op_move || out_blocked;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg  <= op_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            op_reg.mode          <= mode;
            op_reg.is_wide       <= is_wide;
            op_reg.left_operand  <= left_operand;
            op_reg.right_operand <= right_operand;
            op_reg.shift_kind    <= shift_kind;
            op_reg.shift_amount  <= shift_amount;
            op_reg.invert_right  <= invert_right;
            op_reg.bit_mask      <= bit_mask;
        end
        if (op_move)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid  = res_valid_reg;
    assign result_value  = res_reg.value;
    assign nzcv          = res_reg.nzcv;
    assign flags_written = res_reg.flags_written;

    `ASSERT_IMPLY(a_stall_needs_full, clk, rst_n, item_stall, op_valid_reg && res_valid_reg)
    `ASSERT_NEXT(a_move_fills_out, clk, rst_n, op_move, result_valid)
    `ASSERT_NEXT(a_narrow_upper_zero, clk, rst_n, op_move && !op_reg.is_wide, result_value[DW-1:HW] == '0)
    `ASSERT_IMPLY(a_flags_clear, clk, rst_n, result_valid && !flags_written, nzcv == 4'b0000)

endmodule

`default_nettype wire

/* hw/rtl/a64alu_shift.sv */
// Barrel shifter: LSL, LSR, ASR and ROR within a 32- or 64-bit width.
`default_nettype none

module a64alu_shift (
    input  wire logic [a64alu_pkg::DATA_WIDTH-1:0] value,
    input  wire logic                              is_wide,
    input  wire logic [1:0]                        shift_kind,
    input  wire logic [a64alu_pkg::AMT_WIDTH-1:0]  shift_amount,
    output logic      [a64alu_pkg::DATA_WIDTH-1:0] shifted
);

    localparam int DW = a64alu_pkg::DATA_WIDTH;
    localparam int HW = a64alu_pkg::HALF_WIDTH;
    localparam int AW = a64alu_pkg::AMT_WIDTH;

    logic [DW-1:0] mask;
    logic [DW-1:0] vm;
    logic [DW-1:0] sext;
    logic [AW-1:0] amt;

    always_comb
    begin
        mask = a64alu_pkg::width_mask(is_wide);
        vm   = value & mask;
        // In 32-bit mode the amount is taken modulo 32.
        amt  = is_wide ? shift_amount : {1'b0, shift_amount[AW-2:0]};
        sext = is_wide ? vm : {{HW{vm[HW-1]}}, vm[HW-1:0]};
        case (a64alu_pkg::shift_kind_t'(shift_kind))
            a64alu_pkg::SHIFT_LSL: shifted = (vm << amt) & mask;
            a64alu_pkg::SHIFT_LSR: shifted = vm >> amt;
            a64alu_pkg::SHIFT_ASR: shifted = DW'($signed(sext) >>> amt) & mask;
            a64alu_pkg::SHIFT_ROR: shifted = a64alu_pkg::funnel(vm, vm, is_wide, amt);
            default:               shifted = vm;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/a64alu_core.sv */
// Combinational datapath: shifted operand, add/sub with flags, logic, move-wide,
// extract and bitfield move.
`default_nettype none

module a64alu_core (
    input  wire a64alu_pkg::op_t  op,
    output a64alu_pkg::res_t      res
);

    localparam int DW = a64alu_pkg::DATA_WIDTH;
    localparam int HW = a64alu_pkg::HALF_WIDTH;
    localparam int IW = a64alu_pkg::IMM_WIDTH;
    localparam int AW = a64alu_pkg::AMT_WIDTH;

    logic [DW-1:0] mask;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] shift_in;
    logic [1:0]    shift_kind;
    logic [DW-1:0] shifted;
    logic [DW-1:0] sum;
    logic [DW-1:0] diff;
    logic [DW-1:0] field;
    logic [DW-1:0] imm_mask;
    logic [DW-1:0] lo;
    logic [DW-1:0] logic_b;
    logic [DW-1:0] r;
    logic [DW-1:0] ovf_word;
    logic          is_sub;
    logic          carry;
    logic          sign_r;
    logic          sign_v;
    logic [AW-1:0] lsb;
    a64alu_pkg::mode_t mode;

    // One shifter serves the second operand and the UBFM rotate.
    a64alu_shift u_shift (
        .value        (shift_in),
        .is_wide      (op.is_wide),
        .shift_kind   (shift_kind),
        .shift_amount (op.shift_amount),
        .shifted      (shifted)
    );

    always_comb
    begin
        mode       = a64alu_pkg::mode_t'(op.mode);
        mask       = a64alu_pkg::width_mask(op.is_wide);
        a          = op.left_operand & mask;
        shift_in   = (mode == a64alu_pkg::MODE_UBFM) ? op.left_operand : op.right_operand;
        shift_kind = (mode == a64alu_pkg::MODE_UBFM) ? 2'(a64alu_pkg::SHIFT_ROR)
                                                     : op.shift_kind;
        b          = shifted;
        sum        = (a + b) & mask;
        diff       = (a - b) & mask;
        logic_b    = op.invert_right ? (~b & mask) : b;
        field      = {{(DW-IW){1'b0}}, op.right_operand[IW-1:0]} << op.shift_amount;
        imm_mask   = {{(DW-IW){1'b0}}, {IW{1'b1}}} << op.shift_amount;
        lo         = op.right_operand & mask;
        lsb        = op.is_wide ? op.shift_amount : {1'b0, op.shift_amount[AW-2:0]};
        is_sub     = (mode == a64alu_pkg::MODE_SUB) || (mode == a64alu_pkg::MODE_SUBS);

        case (mode)
            a64alu_pkg::MODE_ADD,
            a64alu_pkg::MODE_ADDS: r = sum;
            a64alu_pkg::MODE_SUB,
            a64alu_pkg::MODE_SUBS: r = diff;
            a64alu_pkg::MODE_AND:  r = a & logic_b;
            a64alu_pkg::MODE_ORR:  r = a | logic_b;
            a64alu_pkg::MODE_EOR:  r = a ^ logic_b;
            a64alu_pkg::MODE_MOVZ: r = field;
            a64alu_pkg::MODE_MOVN: r = ~field;
            a64alu_pkg::MODE_MOVK: r = (a & ~imm_mask) | field;
            a64alu_pkg::MODE_EXTR: r = a64alu_pkg::funnel(a, lo, op.is_wide, lsb);
            a64alu_pkg::MODE_UBFM: r = shifted & op.bit_mask;
            default:               r = '0;
        endcase
        r = r & mask;

        // Carry is no-borrow for subtract and carry-out for add.
        carry    = is_sub ? (a >= b) : (sum < a);
        ovf_word = is_sub ? ((a ^ b) & (a ^ r)) : (~(a ^ b) & (a ^ r));
        sign_r   = op.is_wide ? r[DW-1] : r[HW-1];
        sign_v   = op.is_wide ? ovf_word[DW-1] : ovf_word[HW-1];

        res.value         = r;
        res.flags_written = (mode == a64alu_pkg::MODE_ADDS) || (mode == a64alu_pkg::MODE_SUBS);
        res.nzcv          = res.flags_written ? {sign_r, (r == '0), carry, sign_v} : 4'b0000;
    end

endmodule

`default_nettype wire
